// File: hw/rtl/c8ie_pkg.sv
// shared types and constants for the chip8 instruction executor
`timescale 1ns / 1ps
package c8ie_pkg;
  localparam int unsigned MemDepth   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned AddrW      = 12;
  localparam logic [AddrW-1:0] PcReset = 12'd512;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncExec  = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;
  localparam logic [3:0] GrpSys  = 4'h0;
  localparam logic [3:0] GrpJp   = 4'h1;
  localparam logic [3:0] GrpCall = 4'h2;
  localparam logic [3:0] GrpLd   = 4'h6;
  localparam logic [3:0] GrpAdd  = 4'h7;
  localparam logic [3:0] GrpLdi  = 4'hA;
  localparam logic [3:0] GrpDrw  = 4'hD;
  localparam logic [3:0] RegF    = 4'hF;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [4:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] opcode;
    logic        collision;
    logic [7:0]  flag_reg;
    logic        fault;
    logic [63:0] row_bits;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture input item
    logic mem_wr;     // do memory write item
    logic mem_rd_hi;  // issue fetch read of pc
    logic mem_rd_lo;  // issue fetch read of pc+1
    logic op_hi;      // capture opcode high byte
    logic op_lo;      // capture opcode low byte
    logic exec;       // execute non-draw instruction
    logic clr_row;    // clear one frame row (cls sweep)
    logic drw_start;  // set up draw
    logic spr_rd;     // issue sprite byte read
    logic fb_rd;      // read frame row
    logic fb_wr;      // xor sprite into frame row
    logic drw_end;    // finish draw
    logic rd_row;     // read-item frame read
    logic load_out;   // build result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       is_cls;
    logic       is_drw;
    logic       clr_last;
    logic       drw_last;
    logic       mem_clr;  // memory clearing pass running
  } sts_t;
endpackage

// File: hw/rtl/c8ie_if.sv
// valid/ready channel interface carrying one item
`timescale 1ns / 1ps
interface c8ie_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/c8ie_ctrl.sv
// controller state machine sequencing each item
`timescale 1ns / 1ps
module c8ie_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  c8ie_pkg::sts_t sts,
  output c8ie_pkg::ctl_t ctl
);
  import c8ie_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_F1    = 11'b00000000100,
    S_F2    = 11'b00000001000,
    S_F3    = 11'b00000010000,
    S_EXEC  = 11'b00000100000,
    S_CLR   = 11'b00001000000,
    S_SRD   = 11'b00010000000,
    S_FRD   = 11'b00100000000,
    S_FWR   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   busy, busy_next;

  assign in_ready = (state == S_IDLE) && !busy && !sts.mem_clr;
  assign out_valid = busy && (state == S_IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    busy_next = busy;
    if (busy && out_ready && state == S_IDLE) busy_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.latch_in = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FuncWrite: begin ctl.mem_wr = 1'b1; state_next = S_OUT; end
          FuncExec: begin ctl.mem_rd_hi = 1'b1; state_next = S_F1; end
          FuncRead: begin ctl.rd_row = 1'b1; state_next = S_OUT; end
          default: state_next = S_OUT;
        endcase
      end
      S_F1: begin ctl.mem_rd_lo = 1'b1; ctl.op_hi = 1'b1; state_next = S_F2; end
      S_F2: begin ctl.op_lo = 1'b1; state_next = S_F3; end
      S_F3: begin
        if (sts.is_cls) state_next = S_CLR;
        else if (sts.is_drw) begin
          ctl.drw_start = 1'b1;
          state_next = S_SRD;
        end else state_next = S_EXEC;
      end
      S_EXEC: begin ctl.exec = 1'b1; state_next = S_OUT; end
      S_CLR: begin
        ctl.clr_row = 1'b1;
        if (sts.clr_last) state_next = S_EXEC;
      end
      S_SRD: begin
        if (sts.drw_last) begin
          ctl.drw_end = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.spr_rd = 1'b1;
          ctl.fb_rd = 1'b1;
          state_next = S_FRD;
        end
      end
      S_FRD: state_next = S_FWR;
      S_FWR: begin ctl.fb_wr = 1'b1; state_next = S_SRD; end
      S_OUT: begin
        ctl.load_out = 1'b1;
        busy_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      busy <= busy_next;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// File: hw/rtl/c8ie_datapath.sv
// datapath: memory, registers, stack, frame store and draw logic
`timescale 1ns / 1ps
module c8ie_datapath #(
  parameter int unsigned MEM_DEPTH   = c8ie_pkg::MemDepth,
  parameter int unsigned STACK_DEPTH = c8ie_pkg::StackDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  c8ie_pkg::in_item_t in_item,
  input  c8ie_pkg::ctl_t     ctl,
  output c8ie_pkg::sts_t     sts,
  output c8ie_pkg::out_item_t out_item
);
  import c8ie_pkg::*;

  localparam int unsigned MemAw = $clog2(MEM_DEPTH);
  localparam int unsigned SpAw  = $clog2(STACK_DEPTH);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);

  logic [7:0]  mem [MEM_DEPTH];
  logic [11:0] stk [STACK_DEPTH];
  logic [63:0] fb [ScreenH];
  logic [ScreenH-1:0] fb_valid;
  logic [MemAw-1:0] wipe_cnt;
  logic        wiping;

  in_item_t    itm;
  logic [7:0]  v [16];
  logic [11:0] ireg, pc;
  logic [SpW-1:0] sp;
  logic [15:0] op;
  logic [7:0]  rd_byte;
  logic        rd_ok;
  logic [11:0] rd_addr;
  logic        rd_en;
  logic [4:0]  clr_cnt;
  logic [4:0]  line;
  logic [3:0]  rcnt;
  logic [5:0]  xs;
  logic        hit, fault;
  logic [63:0] fb_q, rbits;
  logic [63:0] spr_bits;
  logic        line_over;
  logic [5:0]  cur_line;

  assign cur_line  = {1'b0, line} + {2'b0, rcnt};
  assign line_over = cur_line[5];

  assign sts.func     = itm.func;
  assign sts.is_cls   = (op == OpCls);
  assign sts.is_drw   = (op[15:12] == GrpDrw);
  assign sts.clr_last = (clr_cnt == 5'(ScreenH - 1));
  assign sts.drw_last = (rcnt == op[3:0]) || line_over;
  assign sts.mem_clr  = wiping;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = pc;
    if (ctl.mem_rd_hi) begin rd_en = 1'b1; rd_addr = pc; end
    if (ctl.mem_rd_lo) begin rd_en = 1'b1; rd_addr = pc + 12'd1; end
    if (ctl.spr_rd) begin rd_en = 1'b1; rd_addr = ireg + {8'd0, rcnt}; end
  end

  // clearing pass after reset, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_cnt <= '0;
      wiping <= 1'b1;
    end else if (wiping) begin
      wipe_cnt <= wipe_cnt + 1'b1;
      if (wipe_cnt == MemAw'(MEM_DEPTH - 1)) wiping <= 1'b0;
    end
  end

  // memory: zeroed by the clearing pass, then written by write items
  always_ff @(posedge clk) begin
    if (wiping)
      mem[wipe_cnt] <= 8'd0;
    else if (ctl.mem_wr && ({20'd0, itm.addr} < MEM_DEPTH))
      mem[itm.addr[MemAw-1:0]] <= itm.data;
    if (rd_en) begin
      rd_byte <= mem[rd_addr[MemAw-1:0]];
      rd_ok <= ({20'd0, rd_addr} < MEM_DEPTH);
    end
  end

  assign spr_bits = {(rd_ok ? rd_byte : 8'd0), 56'd0} >> xs;

  always_ff @(posedge clk) begin
    if (ctl.fb_rd) fb_q <= fb_valid[cur_line[4:0]] ? fb[cur_line[4:0]] : 64'd0;
    if (ctl.fb_wr) fb[cur_line[4:0]] <= fb_q ^ spr_bits;
    if (ctl.rd_row) rbits <= fb_valid[itm.row] ? fb[itm.row] : 64'd0;
    else if (ctl.latch_in) rbits <= 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) fb_valid <= '0;
    else if (ctl.clr_row) fb_valid[clr_cnt] <= 1'b0;
    else if (ctl.fb_wr) fb_valid[cur_line[4:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) itm <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      ireg <= 12'd0;
      pc <= PcReset;
      sp <= '0;
      op <= 16'd0;
      clr_cnt <= '0;
      rcnt <= '0;
      line <= '0;
      xs <= '0;
      hit <= 1'b0;
      fault <= 1'b0;
    end else begin
      if (ctl.latch_in) begin
        op <= 16'd0;
        hit <= 1'b0;
        fault <= 1'b0;
        clr_cnt <= '0;
      end
      if (ctl.op_hi) op[15:8] <= rd_ok ? rd_byte : 8'd0;
      if (ctl.op_lo) op[7:0] <= rd_ok ? rd_byte : 8'd0;
      if (ctl.clr_row) clr_cnt <= clr_cnt + 5'd1;
      if (ctl.drw_start) begin
        xs <= v[op[11:8]][5:0];
        line <= v[op[7:4]][4:0];
        rcnt <= '0;
      end
      if (ctl.fb_wr) begin
        rcnt <= rcnt + 4'd1;
        if ((fb_q & spr_bits) != 64'd0) hit <= 1'b1;
      end
      if (ctl.drw_end) begin
        v[RegF] <= {7'd0, hit};
        pc <= pc + 12'd2;
      end
      if (ctl.exec) begin
        case (op[15:12])
          GrpSys: begin
            if (op == OpRet) begin
              if (sp == '0) begin
                fault <= 1'b1;
                pc <= pc + 12'd2;
              end else begin
                sp <= sp - 1'b1;
                pc <= stk[SpAw'(sp - 1'b1)] + 12'd2;
              end
            end else pc <= pc + 12'd2;
          end
          GrpJp: pc <= op[11:0];
          GrpCall: begin
            if (32'(sp) >= STACK_DEPTH) begin
              fault <= 1'b1;
              pc <= pc + 12'd2;
            end else begin
              sp <= sp + 1'b1;
              pc <= op[11:0];
            end
          end
          GrpLd: begin v[op[11:8]] <= op[7:0]; pc <= pc + 12'd2; end
          GrpAdd: begin v[op[11:8]] <= v[op[11:8]] + op[7:0]; pc <= pc + 12'd2; end
          GrpLdi: begin ireg <= op[11:0]; pc <= pc + 12'd2; end
          default: pc <= pc + 12'd2;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && op[15:12] == GrpCall && 32'(sp) < STACK_DEPTH)
      stk[SpAw'(sp)] <= pc;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_item.pc_after  <= pc;
      out_item.opcode    <= op;
      out_item.collision <= hit;
      out_item.flag_reg  <= v[RegF];
      out_item.fault     <= fault;
      out_item.row_bits  <= rbits;
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= STACK_DEPTH) else $error("stack pointer out of range");
  a_pc_even_step: assert property (@(posedge clk) disable iff (rst)
    ctl.drw_end |=> pc == $past(pc) + 12'd2) else $error("draw pc step");
  a_clr_only_cls: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_row |-> op == OpCls) else $error("clear outside cls");
endmodule

// File: hw/rtl/chip8_instruction_executor_unit.sv
// top level of the chip8 instruction executor
`timescale 1ns / 1ps
// usage:
//   one input channel (in) takes items: func 0 writes data at addr into
//   program memory, func 1 executes the instruction at pc, func 2 reads back
//   display row `row`, func 3 only reports pc and vf.
//   one output channel (out) returns exactly one result item per input item.
// sequencing:
//   write and read items need no instruction fetch; other instructions
//   fetch the opcode, high byte then low byte, before they execute; cls
//   clears the display row by row in a sweep, and drw handles each sprite
//   row by a memory read, a frame read and a frame write. one item is in
//   flight at a time; the next is taken once the result has been delivered.
// reset:
//   synchronous, active high. pc goes to 512, registers, index and stack
//   pointer clear; program memory is then zeroed one byte per cycle, all
//   MEM_DEPTH bytes (4096 by default), with in.ready held low; display rows
//   read as zero until written through per-row valid bits.
// stall:
//   a result waits in the output register while out.ready is low; input is
//   held off meanwhile.
module chip8_instruction_executor_unit #(
  parameter int unsigned MEM_DEPTH   = c8ie_pkg::MemDepth,
  parameter int unsigned STACK_DEPTH = c8ie_pkg::StackDepth
) (
  input logic clk,
  input logic rst,
  c8ie_if.sink   in,
  c8ie_if.source out
);
  import c8ie_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // controller: item sequencing and handshakes
  c8ie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath: all architectural state
  c8ie_datapath #(
    .MEM_DEPTH   (MEM_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in.payload),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out.payload)
  );
endmodule
